[hdl/multi_deque_shared_store_core_defines.svh]
// Assertion macros shared by the checker of the shared-store deque core.
`ifndef MULTI_DEQUE_SHARED_STORE_CORE_DEFINES_SVH
`define MULTI_DEQUE_SHARED_STORE_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define MDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define MDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mdq_pkg.sv]
// Package with the operation and status codes of the shared-store deque core.
package mdq_pkg;

   localparam int DEQUE_ID_W  = 4;
   localparam int ID_SPAN     = 1 << DEQUE_ID_W;
   localparam int VALUE_W     = 32;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT,
      MODE_PUSH_BACK,
      MODE_POP_FRONT,
      MODE_POP_BACK
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_EMPTY,
      STATUS_FULL
   } status_type;

endpackage

[hdl/mdq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/multi_deque_shared_store_core.sv]
// Top level of the shared-store deque core: many deques in one circular-region store.
//
//  Channel | Direction | Handshake             | Word
//  --------+-----------+-----------------------+----------------------------------------
//  req     | in        | req_valid / req_ready | req_mode, req_deque_id, req_value
//  rsp     | out       | rsp_valid / rsp_ready | rsp_popped_value, rsp_status
//
// One word is accepted per cycle unless a response stalls. Its response is valid when it
// leaves the input register, as the status register and the store's registered read port
// load at the same edge. Pointers sit in flip-flops and change at that edge, so a
// back-to-back operation on the same deque sees the new front offset and fill count.
// Synchronous reset clears all pointers at once; words are taken from the first cycle after.
// A stalled response lets one more word into the input register, then req_ready drops.
module multi_deque_shared_store_core
   import mdq_pkg::*;
#(
   parameter int NUM_DEQUES      = 16,
   parameter int SLOTS_PER_DEQUE = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [DEQUE_ID_W-1:0]      req_deque_id,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_popped_value,
   output logic [STATUS_W-1:0]        rsp_status
);

   // Only deque numbers that the id field can name get pointer state and store space.
   localparam int LIVE_DEQUES = (NUM_DEQUES < ID_SPAN) ? NUM_DEQUES : ID_SPAN;
   localparam int IDX_W       = (LIVE_DEQUES > 1) ? $clog2(LIVE_DEQUES) : 1;
   localparam int SLOT_W      = $clog2(SLOTS_PER_DEQUE);
   localparam int CNT_W       = $clog2(SLOTS_PER_DEQUE + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int DEPTH       = LIVE_DEQUES * SLOTS_PER_DEQUE;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Input register.
   logic                     in_valid_ff;
   mode_type                 in_mode_ff;
   logic [DEQUE_ID_W-1:0]    in_id_ff;
   logic [VALUE_W-1:0]       in_value_ff;

   // Per-deque pointer state.
   logic [SLOT_W-1:0]        front_ff [LIVE_DEQUES];
   logic [CNT_W-1:0]         count_ff [LIVE_DEQUES];

   // Result register; the popped word itself sits in the store's read register.
   logic                     out_valid_ff;
   status_type               out_status_ff;
   logic                     out_take_ff;

   logic                     advance;
   logic                     load;
   logic                     issue;

   logic                     in_range;
   logic [IDX_W-1:0]         idx;
   logic [SLOT_W-1:0]        cur_front;
   logic [CNT_W-1:0]         cur_count;
   logic                     is_push;
   logic                     is_full;
   logic                     is_empty;
   logic                     op_ok;
   logic [SLOT_W-1:0]        slot;
   logic [SLOT_W-1:0]        front_in;
   logic [CNT_W-1:0]         count_in;
   logic [SLOT_W-1:0]        front_dec;
   status_type               status_in;
   logic [ADDR_W-1:0]        store_addr;
   logic [VALUE_W-1:0]       store_rd_data;

   // Folds an offset below twice the region size back into the region.
   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] region;
      region = SUM_W'(SLOTS_PER_DEQUE);
      if (s >= region) begin
         return SLOT_W'(s - region);
      end
      return SLOT_W'(s);
   endfunction

   // The result register moves whenever it is empty or being taken; the input register
   // can then refill in the same cycle, which keeps one word per cycle flowing.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign load      = req_valid && req_ready;
   assign issue     = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (load) begin
         in_mode_ff  <= mode_type'(req_mode);
         in_id_ff    <= req_deque_id;
         in_value_ff <= req_value;
      end
   end

   // Look up the addressed deque and work out the operation in one pass.
   assign in_range  = int'(in_id_ff) < LIVE_DEQUES;
   assign idx       = in_id_ff[IDX_W-1:0];
   assign cur_front = front_ff[idx];
   assign cur_count = count_ff[idx];
   assign is_push   = (in_mode_ff == MODE_PUSH_FRONT) || (in_mode_ff == MODE_PUSH_BACK);
   assign is_full   = cur_count == CNT_W'(SLOTS_PER_DEQUE);
   assign is_empty  = cur_count == '0;
   assign front_dec = (cur_front == '0) ? SLOT_W'(SLOTS_PER_DEQUE - 1)
                                        : cur_front - SLOT_W'(1);

   always_comb begin
      op_ok    = 1'b0;
      slot     = cur_front;
      front_in = cur_front;
      count_in = cur_count;
      case (in_mode_ff)
         MODE_PUSH_FRONT: begin
            op_ok    = in_range && !is_full;
            slot     = front_dec;
            front_in = front_dec;
            count_in = cur_count + CNT_W'(1);
         end
         MODE_PUSH_BACK: begin
            op_ok    = in_range && !is_full;
            slot     = wrap_slot(SUM_W'(cur_front) + SUM_W'(cur_count));
            count_in = cur_count + CNT_W'(1);
         end
         MODE_POP_FRONT: begin
            op_ok    = in_range && !is_empty;
            slot     = cur_front;
            front_in = wrap_slot(SUM_W'(cur_front) + SUM_W'(1));
            count_in = cur_count - CNT_W'(1);
         end
         MODE_POP_BACK: begin
            op_ok    = in_range && !is_empty;
            slot     = wrap_slot(SUM_W'(cur_front) + SUM_W'(cur_count) - SUM_W'(1));
            count_in = cur_count - CNT_W'(1);
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // Errors and out-of-range deques leave all state alone; a push reports full and a
   // pop reports empty.
   always_comb begin
      if (op_ok) begin
         status_in = STATUS_OK;
      end else if (is_push) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_EMPTY;
      end
   end

   assign store_addr = ADDR_W'(idx) * ADDR_W'(SLOTS_PER_DEQUE) + ADDR_W'(slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIVE_DEQUES; i++) begin
            front_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else if (issue && op_ok) begin
         front_ff[idx] <= front_in;
         count_ff[idx] <= count_in;
      end
   end

   mdq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (issue && op_ok && is_push),
      .wr_addr (store_addr),
      .wr_data (in_value_ff),
      .rd_en   (issue && op_ok && !is_push),
      .rd_addr (store_addr),
      .rd_data (store_rd_data)
   );

   // The read register of the store only loads with a new pop, so it holds through stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (issue) begin
         out_status_ff <= status_in;
         out_take_ff   <= op_ok && !is_push;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_popped_value = out_take_ff ? signed'(store_rd_data) : '0;

endmodule

[hdl/mdq_checker.sv]
// Port-level checker for the shared-store deque core, bound to the top level.
`include "multi_deque_shared_store_core_defines.svh"

module mdq_checker
   import mdq_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_popped_value,
   input logic [STATUS_W-1:0]       rsp_status
);

   logic                        stall;
   logic                        is_error;
   logic [VALUE_W+STATUS_W-1:0] rsp_word;

   assign stall    = rsp_valid && !rsp_ready;
   assign is_error = rsp_valid && (rsp_status != STATUS_OK);
   assign rsp_word = {rsp_popped_value, rsp_status};

   // A stalled response word keeps its contents.
   `MDQ_ASSERT(hold_a, clock, reset, stall |=> rsp_valid && $stable(rsp_word), "word changed")

   // Every error response carries a zero value.
   `MDQ_ASSERT(err_zero_a, clock, reset, is_error |-> rsp_popped_value == '0, "error not zero")

   // Reset empties the pipeline.
   `MDQ_ASSERT_ALWAYS(reset_clear_a, clock, reset |=> !rsp_valid, "valid after reset")

endmodule

bind multi_deque_shared_store_core mdq_checker u_mdq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_popped_value (rsp_popped_value),
   .rsp_status       (rsp_status)
);

[test/testbench.sv]
// Self-checking testbench for the shared-store double-ended queue core.
module testbench
   import mdq_pkg::*;
();

   localparam int NUM_DEQUES      = 16;
   localparam int SLOTS_PER_DEQUE = 64;
   localparam int CLOCK_PERIOD    = 20;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int IDLE_PERCENT    = 31;
   localparam int RANDOM_WORDS    = 250;
   localparam int HOLD_CYCLES     = 150;
   localparam int DRAIN_CYCLES    = 8;

   // One response word as the core should produce it.
   typedef struct packed {
      logic signed [VALUE_W-1:0] popped_value;
      status_type                status;
   } deque_result_type;

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode     = MODE_PUSH_FRONT;
   logic [DEQUE_ID_W-1:0]     req_deque_id = '0;
   logic signed [VALUE_W-1:0] req_value    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   logic signed [VALUE_W-1:0] rsp_popped_value;
   logic [STATUS_W-1:0]       rsp_status;

   // Shadow copy of the deque contents and pointers, updated as each word is accepted.
   logic [VALUE_W-1:0] shadow_store [NUM_DEQUES*SLOTS_PER_DEQUE];
   int                 shadow_front [NUM_DEQUES];
   int                 shadow_fill  [NUM_DEQUES];

   deque_result_type pending_results[$];
   int               error_count    = 0;
   int               cycle_count    = 0;
   bit               sender_idles   = 1'b1;
   bit               receiver_idles = 1'b1;
   bit               hold_request   = 1'b0;

   multi_deque_shared_store_core #(
      .NUM_DEQUES      (NUM_DEQUES),
      .SLOTS_PER_DEQUE (SLOTS_PER_DEQUE)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_deque_id     (req_deque_id),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status)
   );

   always #(CLOCK_PERIOD/2) clock = ~clock;

   // Applies one operation to the shadow deques and returns the response it must produce.
   function automatic deque_result_type apply_deque_op(input mode_type mode,
                                                       input logic [DEQUE_ID_W-1:0] id,
                                                       input logic [VALUE_W-1:0] value);
      deque_result_type res;
      int               d;
      int               slot;
      bit               is_push;
      res.popped_value = '0;
      res.status       = STATUS_OK;
      d       = int'(id);
      is_push = (mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK);
      if (d >= NUM_DEQUES) begin
         // A deque that does not exist looks full to a push and empty to a pop.
         res.status = is_push ? STATUS_FULL : STATUS_EMPTY;
      end else if (is_push) begin
         if (shadow_fill[d] >= SLOTS_PER_DEQUE) begin
            res.status = STATUS_FULL;
         end else begin
            if (mode == MODE_PUSH_FRONT) begin
               shadow_front[d] = (shadow_front[d] + SLOTS_PER_DEQUE - 1) % SLOTS_PER_DEQUE;
               slot = shadow_front[d];
            end else begin
               slot = (shadow_front[d] + shadow_fill[d]) % SLOTS_PER_DEQUE;
            end
            shadow_store[d*SLOTS_PER_DEQUE + slot] = value;
            shadow_fill[d]++;
         end
      end else begin
         if (shadow_fill[d] == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            if (mode == MODE_POP_FRONT) begin
               slot = shadow_front[d];
               shadow_front[d] = (shadow_front[d] + 1) % SLOTS_PER_DEQUE;
            end else begin
               slot = (shadow_front[d] + shadow_fill[d] - 1) % SLOTS_PER_DEQUE;
            end
            res.popped_value = shadow_store[d*SLOTS_PER_DEQUE + slot];
            shadow_fill[d]--;
         end
      end
      return res;
   endfunction

   // Offers one request word and records its expected response once it is taken.
   // Valid is left high afterwards so that back-to-back words need no extra edge.
   task automatic send_word(input mode_type mode, input int deque,
                            input logic [VALUE_W-1:0] value);
      // Each idle cycle is drawn on its own, so the sender idles in about the idle
      // percentage of its cycles.
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_deque_id <= deque[DEQUE_ID_W-1:0];
      req_value    <= value;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_deque_op(mode, deque[DEQUE_ID_W-1:0], value));
   endtask

   // Stops offering words until every outstanding response has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Every operation, the first and last deque, and the extreme values.
   task automatic test_directed_ops();
      send_word(MODE_POP_FRONT,  0, 32'h0000_0000);
      send_word(MODE_POP_BACK,  15, 32'hFFFF_FFFF);
      send_word(MODE_PUSH_FRONT, 0, 32'h7FFF_FFFF);
      send_word(MODE_PUSH_BACK,  0, 32'h8000_0000);
      send_word(MODE_PUSH_FRONT, 0, 32'hFFFF_FFFF);
      send_word(MODE_PUSH_BACK,  0, 32'h0000_0000);
      send_word(MODE_POP_FRONT,  0, 32'h1234_5678);
      send_word(MODE_POP_BACK,   0, 32'h1234_5678);
      send_word(MODE_POP_FRONT,  0, 32'h0);
      send_word(MODE_POP_BACK,   0, 32'h0);
      send_word(MODE_POP_FRONT,  0, 32'h0);
      send_word(MODE_PUSH_BACK, 15, 32'h5555_5555);
      send_word(MODE_PUSH_FRONT,15, 32'hAAAA_AAAA);
      send_word(MODE_PUSH_BACK, 15, 32'h0000_0001);
      send_word(MODE_POP_BACK,  15, 32'h0);
      send_word(MODE_POP_FRONT, 15, 32'h0);
      send_word(MODE_POP_FRONT, 15, 32'h0);
      send_word(MODE_POP_BACK,  15, 32'h0);
      send_word(MODE_PUSH_FRONT, 9, 32'h8000_0001);
      send_word(MODE_POP_BACK,   9, 32'h0);
      wait_for_drain();
   endtask

   // Fills one deque to capacity, pushes while full, empties it and pops while empty.
   // Both sides run without idling here.
   task automatic test_full_deque();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      for (int i = 0; i < SLOTS_PER_DEQUE; i++)
         send_word(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, 5, $urandom);
      send_word(MODE_PUSH_FRONT, 5, $urandom);
      send_word(MODE_PUSH_BACK,  5, $urandom);
      for (int i = 0; i < SLOTS_PER_DEQUE; i++)
         send_word(i[1] ? MODE_POP_FRONT : MODE_POP_BACK, 5, $urandom);
      send_word(MODE_POP_BACK,  5, 32'h0);
      send_word(MODE_POP_FRONT, 5, 32'h0);
      wait_for_drain();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // The receiver holds off for a long stretch while words keep coming, so the
   // core must fill its pipeline and stall the request side.
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++)
         send_word(i[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, 7, $urandom);
      for (int i = 0; i < 12; i++)
         send_word(i[0] ? MODE_POP_BACK : MODE_POP_FRONT, 7, 32'h0);
      wait_for_drain();
   endtask

   // Random traffic. Three words in four go to one busy deque so that it climbs to
   // full during the push-heavy half and falls back to empty in the pop-heavy half.
   task automatic test_random_traffic();
      int       busy_deque;
      int       deque;
      int       push_percent;
      mode_type mode;
      busy_deque = $urandom_range(NUM_DEQUES - 1);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS/2) wait_for_drain();
         push_percent = (n < RANDOM_WORDS/2) ? 85 : 15;
         deque = ($urandom_range(3) != 0) ? busy_deque : $urandom_range(NUM_DEQUES - 1);
         if ($urandom_range(99) < push_percent)
            mode = ($urandom_range(1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         else
            mode = ($urandom_range(1) != 0) ? MODE_POP_FRONT : MODE_POP_BACK;
         send_word(mode, deque, $urandom);
      end
      wait_for_drain();
   endtask

   // Receiver side: random stalls, or a long counted hold-off when one is requested.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (receiver_idles) begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compares each response word taken against the oldest outstanding expectation.
   always @(posedge clock) begin : check_responses
      deque_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response word: popped_value %0d status %0d",
                     $time, rsp_popped_value, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_popped_value !== want.popped_value) begin
               $display("%0t: popped_value mismatch: expected %0d actual %0d",
                        $time, want.popped_value, rsp_popped_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      for (int d = 0; d < NUM_DEQUES; d++) begin
         shadow_front[d] = 0;
         shadow_fill[d]  = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_full_deque();
      test_backpressure();
      test_random_traffic();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[multi_deque_shared_store_core.f]
+incdir+hdl
hdl/mdq_pkg.sv
hdl/mdq_ram.sv
hdl/multi_deque_shared_store_core.sv
hdl/mdq_checker.sv
test/testbench.sv
